FILE: sv/lma_pkg.sv
// shared types and constants for the label metrics accumulator
// no dependencies; imported by the divider and top level

package lma_pkg;

  // defaults for the top level parameters
  localparam int LMA_MAX_LABELS = 256;
  localparam int LMA_COUNT_BITS = 32;
  localparam int LMA_FRAC_BITS  = 16;

  // fixed field widths of the stream interface
  localparam int LABEL_W     = 9;
  localparam int CFG_W       = 9;
  localparam int CNT_OUT_W   = 32;
  localparam int RATIO_OUT_W = 17;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 280;
  localparam int OUT_PAD_W   = OUT_TDATA_W - 6 * CNT_OUT_W - 5 * RATIO_OUT_W;

  localparam logic [CFG_W-1:0] LABEL_COUNT_RST = CFG_W'(256);

  typedef enum logic [1:0] {
    CMD_ACC   = 2'd0,
    CMD_LABEL = 2'd1,
    CMD_TOTAL = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_t;

  typedef enum logic [9:0] {
    S_CLR   = 10'b00_0000_0001,
    S_IDLE  = 10'b00_0000_0010,
    S_ACC   = 10'b00_0000_0100,
    S_LBL   = 10'b00_0000_1000,
    S_TRD   = 10'b00_0001_0000,
    S_TCAP  = 10'b00_0010_0000,
    S_TNEXT = 10'b00_0100_0000,
    S_DIV   = 10'b00_1000_0000,
    S_DWAIT = 10'b01_0000_0000,
    S_OUT   = 10'b10_0000_0000
  } state_t;

  typedef enum logic [1:0] {
    K_ZERO  = 2'd0,
    K_ERR   = 2'd1,
    K_LABEL = 2'd2,
    K_TOT   = 2'd3
  } kind_t;

  // divider status toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

FILE: sv/lma_mem.sv
// one-read one-write synchronous table memory, registered read data
// no dependencies

module lma_mem #(
  parameter int W     = 32,
  parameter int DEPTH = 257,
  parameter int AW    = 9
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [DEPTH];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: sv/lma_div.sv
// iterative restoring divider, one quotient bit per cycle
// depends on lma_pkg for the status struct

module lma_div
  import lma_pkg::*;
#(
  parameter int VW  = 33,
  parameter int DW  = 26,
  parameter int STW = 5,
  parameter int FB  = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [VW-1:0]  rem0,
  input  logic [DW-1:0]  dvd,
  input  logic [VW-1:0]  den,
  input  logic [STW-1:0] steps,
  output logic [FB:0]    q,
  output div_stat_t      stat
);

  logic           busy_r;
  logic           done_r;
  logic [STW-1:0] cnt_r;
  logic [VW-1:0]  rem_r;
  logic [DW-1:0]  dvd_r;
  logic [VW-1:0]  den_r;
  logic [DW-1:0]  q_r;
  logic [VW:0]    trial;
  logic           ge;

  assign trial = {rem_r, dvd_r[DW-1]};
  assign ge    = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        if (den == '0) begin
          // zero divisor gives zero
          q_r    <= '0;
          done_r <= 1'b1;
        end else if (rem0 >= den) begin
          // ratio at or above one is capped
          q_r    <= DW'(1) << FB;
          done_r <= 1'b1;
        end else begin
          busy_r <= 1'b1;
          cnt_r  <= steps;
          rem_r  <= rem0;
          dvd_r  <= dvd;
          den_r  <= den;
          q_r    <= '0;
        end
      end else if (busy_r) begin
        rem_r <= ge ? VW'(trial - {1'b0, den_r}) : trial[VW-1:0];
        q_r   <= {q_r[DW-2:0], ge};
        dvd_r <= dvd_r << 1;
        cnt_r <= cnt_r - STW'(1);
        if (cnt_r == STW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign q         = q_r[FB:0];
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

FILE: sv/label_metrics_accumulator.sv
// top level of the label metrics accumulator: sequencer, totals and result register
// depends on lma_pkg, lma_mem (three count tables) and lma_div (shared divider)

// Per-label precision / recall / F1 counter on a request stream. in_tuser carries the
// command (accumulate, read label, read totals, clear), in_tlast ends a sequence.
// Every request gives exactly one result; out_tuser is the error flag. In an accumulate
// the three count tables are read at acceptance and written back in the next cycle.
// A label read uses the single shared divider, which works out the three ratios one
// bit per cycle. A totals read walks the tables entry by entry, label count + 1
// entries, with three divisions for each entry below the label count that has a
// nonzero observed count, then five more divisions. A clear, and the clearing pass
// after reset, sweep all MAX_LABELS + 1 table entries at one per cycle with
// in_tready low. Configuration writes are taken at any time but are meant for idle.

module label_metrics_accumulator
  import lma_pkg::*;
#(
  parameter int MAX_LABELS = LMA_MAX_LABELS,
  parameter int COUNT_BITS = LMA_COUNT_BITS,
  parameter int FRAC_BITS  = LMA_FRAC_BITS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // request: reference_label [8:0], predicted_label [17:9], zero pad
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   in_tlast,   // last_position
  input  logic [1:0]             in_tuser,   // cmd
  // result: count_correct [31:0], count_model [63:32], count_observed [95:64],
  // count_items [127:96], sequences_correct [159:128], sequences_total [191:160],
  // ratio_precision [208:192], ratio_recall [225:209], ratio_f1 [242:226],
  // ratio_item_accuracy [259:243], ratio_sequence_accuracy [276:260], zero pad
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tuser,  // error
  // label count register
  input  logic                   cfg_wr_en,
  input  logic [CFG_W-1:0]       cfg_wr_data
);

  localparam int NLW   = $clog2(MAX_LABELS + 1);
  localparam int AW    = NLW;
  localparam int DEPTH = MAX_LABELS + 1;
  localparam int SW    = FRAC_BITS + 1 + NLW;
  localparam int VW    = (COUNT_BITS + 1 > NLW) ? COUNT_BITS + 1 : NLW;
  localparam int STW   = $clog2(SW + 1);
  localparam int RW    = FRAC_BITS + 1;

  // divider jobs, run one after another
  typedef enum logic [2:0] {
    JOB_PREC, JOB_REC, JOB_F1, JOB_MP, JOB_MR, JOB_MF, JOB_IACC, JOB_SACC
  } job_t;

  function automatic logic [COUNT_BITS-1:0] sat_add(input logic [COUNT_BITS-1:0] a,
                                                    input logic [COUNT_BITS-1:0] b);
    logic [COUNT_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[COUNT_BITS] ? {COUNT_BITS{1'b1}} : s[COUNT_BITS-1:0];
  endfunction

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] a);
    return (a == {COUNT_BITS{1'b1}}) ? a : a + COUNT_BITS'(1);
  endfunction

  state_t                state_r;
  kind_t                 kind_r;
  job_t                  job_r;
  logic [CFG_W-1:0]      nlab_r;
  logic [LABEL_W-1:0]    lr_r, lt_r;
  logic                  last_r;
  logic                  tot_mode_r;
  logic                  clr_resp_r;
  logic [AW-1:0]         clr_idx_r, idx_r;
  logic [COUNT_BITS-1:0] c_r, m_r, o_r, sc_r, sm_r, so_r;
  logic [COUNT_BITS-1:0] item_r, seqc_r, seqt_r;
  logic                  all_r, ab_r;
  logic [SW-1:0]         mp_r, mr_r, mf_r;
  logic [RW-1:0]         rp_r, rr_r, rf_r, ria_r, rsa_r;
  logic                  out_valid_r, out_tuser_r;
  logic [OUT_TDATA_W-1:0] out_tdata_r;

  // input fields
  logic [LABEL_W-1:0] in_lr, in_lt;
  cmd_t               in_cmd;
  logic               accept;
  assign in_lr  = in_tdata[LABEL_W-1:0];
  assign in_lt  = in_tdata[2*LABEL_W-1:LABEL_W];
  assign in_cmd = cmd_t'(in_tuser);
  assign in_tready = (state_r == S_IDLE);
  assign accept = in_tvalid && in_tready;

  // effective label count, held to 1..MAX_LABELS
  logic [NLW-1:0] nl;
  assign nl = (nlab_r == '0) ? NLW'(1) :
              (32'(nlab_r) > 32'(MAX_LABELS)) ? NLW'(MAX_LABELS) : NLW'(nlab_r);

  // table ports
  logic                  rd_en;
  logic [AW-1:0]         obs_ra, pred_ra;
  logic                  obs_we, pred_we, corr_we;
  logic [AW-1:0]         obs_wa, pred_wa;
  logic [COUNT_BITS-1:0] obs_wd, pred_wd, corr_wd;
  logic [COUNT_BITS-1:0] obs_q, pred_q, corr_q;

  // accumulate decisions
  logic acc_bad, acc_commit, acc_err, acc_ab, acc_all;
  assign acc_bad    = (32'(lr_r) >= 32'(nl)) || (32'(lt_r) >= 32'(nl));
  assign acc_commit = !ab_r && !acc_bad;
  assign acc_err    = !ab_r && acc_bad;
  assign acc_ab     = ab_r || acc_bad;
  assign acc_all    = all_r && !(acc_commit && (lr_r != lt_r));

  always_comb begin
    rd_en   = 1'b0;
    obs_ra  = '0;
    pred_ra = '0;
    if (state_r == S_IDLE) begin
      // read at acceptance so the data is there in the next cycle
      rd_en   = accept;
      obs_ra  = AW'(in_lr);
      pred_ra = (in_cmd == CMD_LABEL) ? AW'(in_lr) : AW'(in_lt);
    end else if (state_r == S_TRD) begin
      rd_en   = 1'b1;
      obs_ra  = idx_r;
      pred_ra = idx_r;
    end
  end

  always_comb begin
    obs_we  = 1'b0;
    pred_we = 1'b0;
    corr_we = 1'b0;
    obs_wa  = clr_idx_r;
    pred_wa = clr_idx_r;
    obs_wd  = '0;
    pred_wd = '0;
    corr_wd = '0;
    if (state_r == S_CLR) begin
      obs_we  = 1'b1;
      pred_we = 1'b1;
      corr_we = 1'b1;
    end else if (state_r == S_ACC) begin
      // read-modify-write of the entries fetched at acceptance
      obs_we  = acc_commit;
      pred_we = acc_commit;
      corr_we = acc_commit && (lr_r == lt_r);
      obs_wa  = AW'(lr_r);
      pred_wa = AW'(lt_r);
      obs_wd  = sat_inc(obs_q);
      pred_wd = sat_inc(pred_q);
      corr_wd = sat_inc(corr_q);
    end
  end

  // correct counts share the observed table's address
  lma_mem #(.W(COUNT_BITS), .DEPTH(DEPTH), .AW(AW)) u_obs (
    .clk(clk), .we(obs_we), .waddr(obs_wa), .wdata(obs_wd),
    .re(rd_en), .raddr(obs_ra), .rdata(obs_q)
  );

  lma_mem #(.W(COUNT_BITS), .DEPTH(DEPTH), .AW(AW)) u_pred (
    .clk(clk), .we(pred_we), .waddr(pred_wa), .wdata(pred_wd),
    .re(rd_en), .raddr(pred_ra), .rdata(pred_q)
  );

  lma_mem #(.W(COUNT_BITS), .DEPTH(DEPTH), .AW(AW)) u_corr (
    .clk(clk), .we(corr_we), .waddr(obs_wa), .wdata(corr_wd),
    .re(rd_en), .raddr(obs_ra), .rdata(corr_q)
  );

  // divider operands by job
  logic           div_start;
  logic [VW-1:0]  div_rem0, div_den;
  logic [SW-1:0]  div_dvd;
  logic [STW-1:0] div_steps;
  logic [RW-1:0]  div_q;
  div_stat_t      div_stat;

  assign div_start = (state_r == S_DIV) && !div_stat.busy;

  always_comb begin
    div_rem0  = '0;
    div_den   = '0;
    div_dvd   = '0;
    div_steps = STW'(FRAC_BITS);
    case (job_r)
      JOB_PREC: begin
        div_rem0 = VW'(c_r);
        div_den  = VW'(m_r);
      end
      JOB_REC: begin
        div_rem0 = VW'(c_r);
        div_den  = VW'(o_r);
      end
      JOB_F1: begin
        // 2c / (m + o), both without saturation
        div_rem0 = VW'({c_r, 1'b0});
        div_den  = VW'(m_r) + VW'(o_r);
      end
      JOB_MP: begin
        div_dvd   = mp_r;
        div_den   = VW'(nl);
        div_steps = STW'(SW);
      end
      JOB_MR: begin
        div_dvd   = mr_r;
        div_den   = VW'(nl);
        div_steps = STW'(SW);
      end
      JOB_MF: begin
        div_dvd   = mf_r;
        div_den   = VW'(nl);
        div_steps = STW'(SW);
      end
      JOB_IACC: begin
        div_rem0 = VW'(sc_r);
        div_den  = VW'(item_r);
      end
      JOB_SACC: begin
        div_rem0 = VW'(seqc_r);
        div_den  = VW'(seqt_r);
      end
      default: ;
    endcase
  end

  lma_div #(.VW(VW), .DW(SW), .STW(STW), .FB(FRAC_BITS)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .rem0(div_rem0), .dvd(div_dvd),
    .den(div_den), .steps(div_steps), .q(div_q), .stat(div_stat)
  );

  // result assembly
  kind_t                  out_kind;
  logic                   out_free, out_load;
  logic [CNT_OUT_W-1:0]   f_cc, f_cm, f_co, f_it, f_sc, f_st;
  logic [RATIO_OUT_W-1:0] f_p, f_r, f_f, f_ia, f_sa;
  logic [OUT_TDATA_W-1:0] out_tdata_nxt;

  assign out_free = !out_valid_r || out_tready;
  assign out_kind = (state_r == S_ACC) ? (acc_err ? K_ERR : K_ZERO) : kind_r;
  assign out_load = ((state_r == S_ACC) || (state_r == S_OUT)) && out_free;

  always_comb begin
    f_cc = '0; f_cm = '0; f_co = '0; f_it = '0; f_sc = '0; f_st = '0;
    f_p  = '0; f_r  = '0; f_f  = '0; f_ia = '0; f_sa = '0;
    case (out_kind)
      K_LABEL: begin
        f_cc = CNT_OUT_W'(c_r);
        f_cm = CNT_OUT_W'(m_r);
        f_co = CNT_OUT_W'(o_r);
        f_p  = RATIO_OUT_W'(rp_r);
        f_r  = RATIO_OUT_W'(rr_r);
        f_f  = RATIO_OUT_W'(rf_r);
      end
      K_TOT: begin
        f_cc = CNT_OUT_W'(sc_r);
        f_cm = CNT_OUT_W'(sm_r);
        f_co = CNT_OUT_W'(so_r);
        f_it = CNT_OUT_W'(item_r);
        f_sc = CNT_OUT_W'(seqc_r);
        f_st = CNT_OUT_W'(seqt_r);
        f_p  = RATIO_OUT_W'(rp_r);
        f_r  = RATIO_OUT_W'(rr_r);
        f_f  = RATIO_OUT_W'(rf_r);
        f_ia = RATIO_OUT_W'(ria_r);
        f_sa = RATIO_OUT_W'(rsa_r);
      end
      default: ;
    endcase
    out_tdata_nxt = {{OUT_PAD_W{1'b0}}, f_sa, f_ia, f_f, f_r, f_p,
                     f_st, f_sc, f_it, f_co, f_cm, f_cc};
  end

  // config register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nlab_r <= LABEL_COUNT_RST;
    end else if (cfg_wr_en) begin
      nlab_r <= cfg_wr_data;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_tdata_r <= out_tdata_nxt;
      out_tuser_r <= (out_kind == K_ERR);
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLR;
      clr_idx_r  <= '0;
      clr_resp_r <= 1'b0;
      item_r     <= '0;
      seqc_r     <= '0;
      seqt_r     <= '0;
      all_r      <= 1'b1;
      ab_r       <= 1'b0;
    end else begin
      unique case (state_r)
        S_CLR: begin
          clr_idx_r <= clr_idx_r + AW'(1);
          if (clr_idx_r == AW'(DEPTH - 1)) begin
            if (clr_resp_r) begin
              kind_r  <= K_ZERO;
              state_r <= S_OUT;
            end else begin
              state_r <= S_IDLE;
            end
          end
        end
        S_IDLE: begin
          if (accept) begin
            lr_r   <= in_lr;
            lt_r   <= in_lt;
            last_r <= in_tlast;
            unique case (in_cmd)
              CMD_ACC: state_r <= S_ACC;
              CMD_LABEL: begin
                if (32'(in_lr) >= 32'(nl)) begin
                  kind_r  <= K_ERR;
                  state_r <= S_OUT;
                end else begin
                  state_r <= S_LBL;
                end
              end
              CMD_TOTAL: begin
                sc_r       <= '0;
                sm_r       <= '0;
                so_r       <= '0;
                mp_r       <= '0;
                mr_r       <= '0;
                mf_r       <= '0;
                idx_r      <= '0;
                tot_mode_r <= 1'b1;
                state_r    <= S_TRD;
              end
              CMD_CLEAR: begin
                item_r     <= '0;
                seqc_r     <= '0;
                seqt_r     <= '0;
                all_r      <= 1'b1;
                ab_r       <= 1'b0;
                clr_idx_r  <= '0;
                clr_resp_r <= 1'b1;
                state_r    <= S_CLR;
              end
              default: ;
            endcase
          end
        end
        S_ACC: begin
          if (acc_commit) begin
            item_r <= sat_inc(item_r);
          end
          if (last_r) begin
            // sequence ends here, counted only if never aborted
            if (!acc_ab) begin
              seqt_r <= sat_inc(seqt_r);
              if (acc_all) begin
                seqc_r <= sat_inc(seqc_r);
              end
            end
            all_r <= 1'b1;
            ab_r  <= 1'b0;
          end else begin
            all_r <= acc_all;
            ab_r  <= acc_ab;
          end
          if (out_free) begin
            state_r <= S_IDLE;
          end else begin
            kind_r  <= acc_err ? K_ERR : K_ZERO;
            state_r <= S_OUT;
          end
        end
        S_LBL: begin
          c_r        <= corr_q;
          m_r        <= pred_q;
          o_r        <= obs_q;
          tot_mode_r <= 1'b0;
          job_r      <= JOB_PREC;
          state_r    <= S_DIV;
        end
        S_TRD: state_r <= S_TCAP;
        S_TCAP: begin
          c_r <= corr_q;
          m_r <= pred_q;
          o_r <= obs_q;
          if (obs_q != '0) begin
            sc_r <= sat_add(sc_r, corr_q);
            sm_r <= sat_add(sm_r, pred_q);
            so_r <= sat_add(so_r, obs_q);
            // the slot at the label count joins the sums but not the averages
            if (NLW'(idx_r) < nl) begin
              job_r   <= JOB_PREC;
              state_r <= S_DIV;
            end else begin
              state_r <= S_TNEXT;
            end
          end else begin
            state_r <= S_TNEXT;
          end
        end
        S_TNEXT: begin
          if (NLW'(idx_r) == nl) begin
            job_r   <= JOB_MP;
            state_r <= S_DIV;
          end else begin
            idx_r   <= idx_r + AW'(1);
            state_r <= S_TRD;
          end
        end
        S_DIV: begin
          if (!div_stat.busy) begin
            state_r <= S_DWAIT;
          end
        end
        S_DWAIT: begin
          if (div_stat.done) begin
            state_r <= S_DIV;
            case (job_r)
              JOB_PREC: begin
                rp_r  <= div_q;
                job_r <= JOB_REC;
              end
              JOB_REC: begin
                rr_r  <= div_q;
                job_r <= JOB_F1;
              end
              JOB_F1: begin
                rf_r <= div_q;
                if (tot_mode_r) begin
                  mp_r    <= mp_r + SW'(rp_r);
                  mr_r    <= mr_r + SW'(rr_r);
                  mf_r    <= mf_r + SW'(div_q);
                  state_r <= S_TNEXT;
                end else begin
                  kind_r  <= K_LABEL;
                  state_r <= S_OUT;
                end
              end
              JOB_MP: begin
                rp_r  <= div_q;
                job_r <= JOB_MR;
              end
              JOB_MR: begin
                rr_r  <= div_q;
                job_r <= JOB_MF;
              end
              JOB_MF: begin
                rf_r  <= div_q;
                job_r <= JOB_IACC;
              end
              JOB_IACC: begin
                ria_r <= div_q;
                job_r <= JOB_SACC;
              end
              JOB_SACC: begin
                rsa_r   <= div_q;
                kind_r  <= K_TOT;
                state_r <= S_OUT;
              end
              default: ;
            endcase
          end
        end
        S_OUT: begin
          if (out_free) begin
            clr_resp_r <= 1'b0;
            state_r    <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule
